FILE: design/dxt_pkg.sv
// ----------------------------------------------------------------------------
// dxt_pkg
// Shared types, constants and arithmetic helpers of the block texture decoder.
// ----------------------------------------------------------------------------
package dxt_pkg;

  // Image size limits in pixels
  localparam int MaxWidth  = 4096;
  localparam int MaxHeight = 4096;

  // Block format codes (code 3 decodes as interpolated alpha)
  localparam logic [1:0] FMT_DXT1 = 2'd0;
  localparam logic [1:0] FMT_DXT3 = 2'd1;
  localparam logic [1:0] FMT_DXT5 = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // Configuration register set
  typedef struct packed {
    logic [1:0]  fmt;
    logic [12:0] width;
    logic [12:0] height;
  } cfg_t;

  // One classified block as queued between front and back
  typedef struct packed {
    logic [1:0]        fmt;
    logic              three_color;  // DXT1 with endpoint0 <= endpoint1
    logic              ramp7;        // DXT5 eight-level ramp
    logic [9:0]        col;
    logic [9:0]        row;
    logic [2:0]        size_w;       // 1..4 texel columns
    logic [2:0]        size_h;       // 1..4 texel rows
    logic [31:0]       idx;          // 2-bit color indexes
    logic [63:0]       alpha_bits;   // low block word, alpha codes
    logic [23:0]       ep0;          // expanded endpoint 0, RGB
    logic [23:0]       ep1;          // expanded endpoint 1, RGB
    logic [2:0][9:0]   mix2;         // blend numerators for entry 2, per channel
    logic [2:0][9:0]   mix3;         // blend numerators for entry 3, per channel
    logic [5:0][10:0]  ramp_num;     // alpha ramp numerators, levels 2..7
  } blk_t;

  // Queue status seen by the top level
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // Expand RGB565 to RGB888 by bit replication
  function automatic logic [23:0] expand565(input logic [15:0] c);
    logic [4:0] r5;
    logic [5:0] g6;
    logic [4:0] b5;
    r5 = c[15:11];
    g6 = c[10:5];
    b5 = c[4:0];
    return {r5, r5[4:2], g6, g6[5:4], b5, b5[4:2]};
  endfunction

  // x / 3 for x < 768, by reciprocal multiply
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] p;
    p = 21'(x) * 21'd683;
    return p[18:11];
  endfunction

  // x / 5 for x < 1280, by reciprocal multiply
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [23:0] p;
    p = 24'(x) * 24'd6554;
    return p[22:15];
  endfunction

  // x / 7 for x < 1792, by reciprocal multiply
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [23:0] p;
    p = 24'(x) * 24'd4682;
    return p[22:15];
  endfunction

endpackage

FILE: design/dxt_front.sv
// ----------------------------------------------------------------------------
// dxt_front
// Accepts blocks, tracks the block position and precomputes blend sums.
// ----------------------------------------------------------------------------
module dxt_front import dxt_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  cfg_t         cfg,
  input  logic         in_valid,
  input  logic         in_first,
  input  logic [127:0] in_data,
  input  logic         q_full,
  output logic         in_ready,
  output logic         push,
  output blk_t         push_blk
);

  logic [9:0]  col_r, col_nxt;
  logic [9:0]  row_r, row_nxt;
  logic [9:0]  start_col, start_row;
  logic [12:0] w, h;
  logic [10:0] bpr;
  logic [63:0] lo, hi;
  logic [15:0] c0, c1;
  logic [10:0] a0e, a1e;
  logic        ramp7;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;
  assign lo       = in_data[63:0];
  assign hi       = in_data[127:64];

  // Clamp image size and derive blocks per row
  always_comb begin
    if (cfg.width == 13'd0) begin
      w = 13'd1;
    end else if (cfg.width > 13'(MaxWidth)) begin
      w = 13'(MaxWidth);
    end else begin
      w = cfg.width;
    end
    if (cfg.height == 13'd0) begin
      h = 13'd1;
    end else if (cfg.height > 13'(MaxHeight)) begin
      h = 13'(MaxHeight);
    end else begin
      h = cfg.height;
    end
    bpr = (w[12:2] == 11'd0) ? 11'd1 : w[12:2];
  end

  // Position of this block and the next one in raster order
  always_comb begin
    start_col = in_first ? 10'd0 : col_r;
    start_row = in_first ? 10'd0 : row_r;
    if ((11'(start_col) + 11'd1 >= bpr) || (start_col == 10'd1023)) begin
      col_nxt = 10'd0;
      row_nxt = start_row + 10'd1;
    end else begin
      col_nxt = start_col + 10'd1;
      row_nxt = start_row;
    end
  end

  // Classify the block and form the blend numerators
  always_comb begin
    if (cfg.fmt == FMT_DXT1) begin
      c0 = lo[15:0];
      c1 = lo[31:16];
      push_blk.idx = lo[63:32];
      push_blk.three_color = (c0 <= c1);
    end else begin
      c0 = hi[15:0];
      c1 = hi[31:16];
      push_blk.idx = hi[63:32];
      push_blk.three_color = 1'b0;
    end
    push_blk.fmt        = cfg.fmt;
    push_blk.col        = start_col;
    push_blk.row        = start_row;
    push_blk.size_w     = (w < 13'd4) ? w[2:0] : 3'd4;
    push_blk.size_h     = (h < 13'd4) ? h[2:0] : 3'd4;
    push_blk.alpha_bits = lo;
    push_blk.ep0        = expand565(c0);
    push_blk.ep1        = expand565(c1);
    for (int j = 0; j < 3; j++) begin
      if (push_blk.three_color) begin
        push_blk.mix2[j] = 10'(push_blk.ep0[8*j +: 8]) + 10'(push_blk.ep1[8*j +: 8]);
      end else begin
        push_blk.mix2[j] = {1'b0, push_blk.ep0[8*j +: 8], 1'b0}
                         + 10'(push_blk.ep1[8*j +: 8]);
      end
      push_blk.mix3[j] = 10'(push_blk.ep0[8*j +: 8])
                       + {1'b0, push_blk.ep1[8*j +: 8], 1'b0};
    end
    a0e   = 11'(lo[7:0]);
    a1e   = 11'(lo[15:8]);
    ramp7 = (lo[7:0] > lo[15:8]);
    push_blk.ramp7 = ramp7;
    for (int k = 1; k <= 6; k++) begin
      if (ramp7) begin
        push_blk.ramp_num[k-1] = 11'(7 - k) * a0e + 11'(k) * a1e + 11'd3;
      end else if (k <= 4) begin
        push_blk.ramp_num[k-1] = 11'(5 - k) * a0e + 11'(k) * a1e + 11'd2;
      end else begin
        push_blk.ramp_num[k-1] = 11'd0;
      end
    end
  end

  // Advance the block position on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= 10'd0;
      row_r <= 10'd0;
    end else if (push) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

FILE: design/dxt_queue.sv
// ----------------------------------------------------------------------------
// dxt_queue
// Two-entry block queue between the front and the back.
// ----------------------------------------------------------------------------
module dxt_queue import dxt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  blk_t    push_blk,
  input  logic    pop,
  output blk_t    head,
  output q_stat_t stat
);

  blk_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  assign head       = mem_r[rd_ptr_r];
  assign stat.empty = (count_r == 2'd0);
  assign stat.full  = (count_r == 2'd2);

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_blk;
    end
  end

endmodule

FILE: design/dxt_back.sv
// ----------------------------------------------------------------------------
// dxt_back
// Finishes palette and alpha ramp of a block and emits one texel per cycle while out_ready holds.
// ----------------------------------------------------------------------------
module dxt_back import dxt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  blk_t        head,
  input  logic        q_empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [55:0] out_data,
  output logic        out_last
);

  // Block being emitted
  logic              work_v_r, work_v_nxt;
  logic [1:0]        fmt_r;
  logic              three_r;
  logic [9:0]        col_r, row_r;
  logic [2:0]        size_w_r, size_h_r;
  logic [31:0]       idx_r;
  logic [63:0]       abits_r;
  logic [3:0][23:0]  pal_r;
  logic [7:0][7:0]   ramp_r;
  logic [1:0]        c_r, c_nxt, r_r, r_nxt;

  // Finished palette and ramp of the queue head
  logic [3:0][23:0]  pal_nxt;
  logic [7:0][7:0]   ramp_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       texel_r;
  logic [11:0]       px_r, py_r;
  logic              last_r;

  logic              out_free, emit, row_end, at_last, load;
  logic [3:0]        pos;
  logic [1:0]        ci;
  logic [2:0]        acode;
  logic [5:0]        abase;
  logic [7:0]        alpha;

  assign out_valid = out_valid_r;
  assign out_data  = {py_r, px_r, texel_r};
  assign out_last  = last_r;

  // Divide the blend sums of the head block
  always_comb begin
    pal_nxt[0] = head.ep0;
    pal_nxt[1] = head.ep1;
    for (int j = 0; j < 3; j++) begin
      if (head.three_color) begin
        pal_nxt[2][8*j +: 8] = head.mix2[j][8:1];
        pal_nxt[3][8*j +: 8] = 8'd0;
      end else begin
        pal_nxt[2][8*j +: 8] = div3(head.mix2[j]);
        pal_nxt[3][8*j +: 8] = div3(head.mix3[j]);
      end
    end
    ramp_nxt[0] = head.alpha_bits[7:0];
    ramp_nxt[1] = head.alpha_bits[15:8];
    for (int k = 1; k <= 6; k++) begin
      if (head.ramp7) begin
        ramp_nxt[k+1] = div7(head.ramp_num[k-1]);
      end else if (k <= 4) begin
        ramp_nxt[k+1] = div5(head.ramp_num[k-1]);
      end else if (k == 5) begin
        ramp_nxt[k+1] = 8'd0;
      end else begin
        ramp_nxt[k+1] = 8'hFF;
      end
    end
  end

  // Emit and load control
  always_comb begin
    out_free   = !out_valid_r || out_ready;
    emit       = work_v_r && out_free;
    row_end    = ({1'b0, c_r} == size_w_r - 3'd1);
    at_last    = row_end && ({1'b0, r_r} == size_h_r - 3'd1);
    load       = !q_empty && (!work_v_r || (emit && at_last));
    pop        = load;
    work_v_nxt = work_v_r;
    if (load) begin
      work_v_nxt = 1'b1;
    end else if (emit && at_last) begin
      work_v_nxt = 1'b0;
    end
    c_nxt = c_r;
    r_nxt = r_r;
    if (load) begin
      c_nxt = 2'd0;
      r_nxt = 2'd0;
    end else if (emit) begin
      if (row_end) begin
        c_nxt = 2'd0;
        r_nxt = r_r + 2'd1;
      end else begin
        c_nxt = c_r + 2'd1;
      end
    end
    out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  // Select color and alpha of the current texel
  always_comb begin
    pos   = {r_r, c_r};
    ci    = idx_r[{pos, 1'b0} +: 2];
    abase = 6'd16 + {2'b00, pos} + {1'b0, pos, 1'b0};
    acode = abits_r[abase +: 3];
    case (fmt_r)
      FMT_DXT1: alpha = (three_r && (ci == 2'd3)) ? 8'd0 : 8'hFF;
      FMT_DXT3: alpha = {abits_r[{pos, 2'b00} +: 4], 4'b0000};
      default:  alpha = ramp_r[acode];
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      c_r         <= 2'd0;
      r_r         <= 2'd0;
    end else begin
      work_v_r    <= work_v_nxt;
      out_valid_r <= out_valid_nxt;
      c_r         <= c_nxt;
      r_r         <= r_nxt;
    end
  end

  // Capture the next block
  always_ff @(posedge clk) begin
    if (load) begin
      fmt_r    <= head.fmt;
      three_r  <= head.three_color;
      col_r    <= head.col;
      row_r    <= head.row;
      size_w_r <= head.size_w;
      size_h_r <= head.size_h;
      idx_r    <= head.idx;
      abits_r  <= head.alpha_bits;
      pal_r    <= pal_nxt;
      ramp_r   <= ramp_nxt;
    end
  end

  // Hold the texel beat until taken
  always_ff @(posedge clk) begin
    if (emit) begin
      texel_r <= {alpha, pal_r[ci]};
      px_r    <= {col_r, c_r};
      py_r    <= {row_r, r_r};
      last_r  <= at_last;
    end
  end

endmodule

FILE: design/dxt_block_texture_decoder.sv
// A block's beat is stored in the queue, then loaded into the work registers, then its texels
// pass the texel output register, one per cycle while out_tready holds, a rate set by the single
// texel output register; a block gives 16 texels (width x height texels for images under 4 pixels).
// Input beats keep flowing into a two-entry queue while texels drain, until it is full.
// Reset (synchronous, rst_n low): queue and texel output empty, position at
// column 0 row 0, format DXT1, width 4, height 4.
// ----------------------------------------------------------------------------
// dxt_block_texture_decoder
// DXT1/DXT3/DXT5 4x4 block decoder emitting ARGB texels with coordinates.
// ----------------------------------------------------------------------------
module dxt_block_texture_decoder import dxt_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  // Configuration port
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready,
  // Block input
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // [63:0] block_low, [127:64] block_high
  input  logic         in_tuser,   // [0] first_block
  // Texel output
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [55:0]  out_tdata,  // [31:0] texel, [43:32] pixel_x, [55:44] pixel_y
  output logic         out_tlast   // last_texel
);

  cfg_t    cfg_r;
  logic    cfg_wr;
  logic    push, pop;
  blk_t    push_blk, head;
  q_stat_t q_st;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fmt    <= FMT_DXT1;
      cfg_r.width  <= 13'd4;
      cfg_r.height <= 13'd4;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_FORMAT: cfg_r.fmt    <= cfg_pwdata[1:0];
        REG_WIDTH:  cfg_r.width  <= cfg_pwdata[12:0];
        REG_HEIGHT: cfg_r.height <= cfg_pwdata[12:0];
        default:    cfg_r        <= cfg_r;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (cfg_paddr[3:2])
      REG_FORMAT: cfg_prdata = {30'd0, cfg_r.fmt};
      REG_WIDTH:  cfg_prdata = {19'd0, cfg_r.width};
      REG_HEIGHT: cfg_prdata = {19'd0, cfg_r.height};
      default:    cfg_prdata = 32'd0;
    endcase
  end

  dxt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_tvalid),
    .in_first (in_tuser),
    .in_data  (in_tdata),
    .q_full   (q_st.full),
    .in_ready (in_tready),
    .push     (push),
    .push_blk (push_blk)
  );

  dxt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_blk (push_blk),
    .pop      (pop),
    .head     (head),
    .stat     (q_st)
  );

  dxt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_empty   (q_st.empty),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

  // A full queue must hold off the input side
  assert property (@(posedge clk) disable iff (!rst_n)
    q_st.full |-> !in_tready)
    else $error("queue full while input ready");

  // Texels of one block follow without gaps
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap inside a block's texels");

  // A queued block is offered after the previous block's last texel is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast && !q_st.empty |-> ##[1:2] out_tvalid)
    else $error("queued block not started");

  // The queue only fills through an accepted beat
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(q_st.full) |-> $past(in_tvalid && in_tready))
    else $error("queue filled without an input beat");

endmodule
